@@ rtl/sci_pkg.sv @@
// Package with the sizes and the shared cell control type of the sorted byte store.
`timescale 1ns / 1ps
package sci_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 5;

	typedef struct packed {
		logic       insert;
		logic       rotate;
		logic [7:0] new_char;
	} cell_ctl_t;

endpackage

@@ rtl/sorted_char_insert.sv @@
// Top level of the sorted byte store: a ring of cells and the emission sequencer.
//
// A request on the input channel (in_valid, in_ready, new_char) carries one byte.
// In the cycle it is accepted the byte is placed into the ring of CAPACITY cells
// after any equal entries, every greater entry moving one cell up. The ring then
// rotates once round, CAPACITY steps, and cell 0 feeds the output register, so
// the stored entries leave in ascending order on the output channel with their
// position, last_entry on the final one and rejected_full when the store was
// full and the byte was dropped. An accepted request moves the state register to
// the rotation, and each emitting step loads the output register from cell 0; the
// ring moves a single cell per step.
// A stalled receiver holds the output register and halts the rotation; steps
// past the last valid entry need no output and proceed regardless.
// A new request is taken once the rotation has finished, even while the last
// result still waits. Reset empties the store; cell contents are not cleared.
`timescale 1ns / 1ps
module sorted_char_insert (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                new_char,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                entry_value,
	output logic [sci_pkg::POS_W-1:0] entry_position,
	output logic                      last_entry,
	output logic                      rejected_full
);

	typedef enum logic {
		IDLE,
		ROTATE
	} state_t;

	state_t                    state_q;
	logic [sci_pkg::CNT_W-1:0] count_q;
	logic [sci_pkg::IDX_W-1:0] step_q;
	logic                      rej_q;
	logic                      out_valid_q;
	logic [7:0]                value_q;
	logic [sci_pkg::POS_W-1:0] pos_q;
	logic                      last_q;
	logic                      rejected_q;

	sci_pkg::cell_ctl_t ctl;
	logic               accept;
	logic               full;
	logic               emitting;
	logic               advance;
	logic [7:0]         values [sci_pkg::CAPACITY];
	logic               gts    [sci_pkg::CAPACITY];

	assign accept   = in_valid && in_ready;
	assign full     = count_q == sci_pkg::CNT_W'(sci_pkg::CAPACITY);
	assign emitting = (state_q == ROTATE) && (sci_pkg::CNT_W'(step_q) < count_q);
	assign advance  = (state_q == ROTATE) && (!emitting || !out_valid_q || out_ready);

	assign ctl.insert   = accept && !full;
	assign ctl.rotate   = advance;
	assign ctl.new_char = new_char;

	genvar i;
	generate
		for (i = 0; i < sci_pkg::CAPACITY; i++) begin : g_cell
			sci_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.valid      (sci_pkg::CNT_W'(i) < count_q),
				.tail       (sci_pkg::CNT_W'(i) == count_q),
				.prev_gt    ((i == 0) ? 1'b0 : gts[(i + sci_pkg::CAPACITY - 1) % sci_pkg::CAPACITY]),
				.prev_value (values[(i + sci_pkg::CAPACITY - 1) % sci_pkg::CAPACITY]),
				.next_value (values[(i + 1) % sci_pkg::CAPACITY]),
				.gt         (gts[i]),
				.value      (values[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			step_q      <= '0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && emitting) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= ROTATE;
						step_q  <= '0;
						rej_q   <= full;
						if (!full) begin
							count_q <= count_q + sci_pkg::CNT_W'(1);
						end
					end
				end
				ROTATE: begin
					if (advance) begin
						if (step_q == sci_pkg::IDX_W'(sci_pkg::CAPACITY - 1)) begin
							state_q <= IDLE;
						end else begin
							step_q <= step_q + sci_pkg::IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emitting) begin
			value_q    <= values[0];
			pos_q      <= sci_pkg::POS_W'(step_q);
			last_q     <= (sci_pkg::CNT_W'(step_q) + sci_pkg::CNT_W'(1)) == count_q;
			rejected_q <= rej_q;
		end
	end

	assign in_ready       = state_q == IDLE;
	assign out_valid      = out_valid_q;
	assign entry_value    = value_q;
	assign entry_position = pos_q;
	assign last_entry     = last_q;
	assign rejected_full  = rejected_q;

endmodule

@@ rtl/sci_cell.sv @@
// One cell of the store: holds a byte, inserts new or lower-neighbour bytes, rotates down.
`timescale 1ns / 1ps
module sci_cell (
	input  logic               clk,
	input  sci_pkg::cell_ctl_t ctl,
	input  logic               valid,
	input  logic               tail,
	input  logic               prev_gt,
	input  logic [7:0]         prev_value,
	input  logic [7:0]         next_value,
	output logic               gt,
	output logic [7:0]         value
);

	logic [7:0] value_q;

	assign gt    = valid && (ctl.new_char < value_q);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.insert && (gt || tail)) begin
			value_q <= prev_gt ? prev_value : ctl.new_char;
		end else if (ctl.rotate) begin
			value_q <= next_value;
		end
	end

endmodule

@@ rtl/sci_checker.sv @@
// Port-level checks on the sorted byte store, bound to its top level.
`timescale 1ns / 1ps
module sci_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [7:0]                entry_value,
	input logic [sci_pkg::POS_W-1:0] entry_position,
	input logic                      last_entry,
	input logic                      rejected_full
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_value)
			&& $stable(entry_position))
		else $error("stalled result changed");

	// An accepted request keeps the block busy for the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken back to back");

	// More entries follow a result that is not the last, so no request is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_entry |-> !in_ready)
		else $error("request taken in the middle of a run");

	// A rejected run lists a full store, so it ends at the top position.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected_full && last_entry
			|-> entry_position == sci_pkg::POS_W'(sci_pkg::CAPACITY - 1))
		else $error("rejected run does not end at the top entry");

endmodule

bind sorted_char_insert sci_checker u_sci_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.entry_value    (entry_value),
	.entry_position (entry_position),
	.last_entry     (last_entry),
	.rejected_full  (rejected_full)
);

@@ test/tb_sorted_char_insert.sv @@
// Self-checking testbench for the sorted byte store: random handshakes, insertion predictor.
`timescale 1ns / 1ps
module tb_sorted_char_insert;

	typedef struct packed {
		logic [7:0]                value;
		logic [sci_pkg::POS_W-1:0] position;
		logic                      last;
		logic                      rejected;
	} entry_t;

	class sorted_store_board;
		logic [7:0] store [sci_pkg::CAPACITY];
		int         count;
		entry_t     pending_entries [$];
		int         mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function void note_request(logic [7:0] c);
			int   slot;
			logic rej;
			entry_t e;
			rej = 1'b0;
			if (count >= sci_pkg::CAPACITY) begin
				rej = 1'b1;
			end else begin
				slot = count;
				while (slot > 0 && store[slot - 1] > c) begin
					store[slot] = store[slot - 1];
					slot--;
				end
				store[slot] = c;
				count++;
			end
			if (count == 0) begin
				e = '{value: 8'd0, position: '0, last: 1'b1, rejected: rej};
				pending_entries.push_back(e);
			end else begin
				for (int k = 0; k < count; k++) begin
					e.value    = store[k];
					e.position = k[sci_pkg::POS_W-1:0];
					e.last     = (k == count - 1);
					e.rejected = rej;
					pending_entries.push_back(e);
				end
			end
		endfunction

		function void check_entry(entry_t got);
			entry_t want;
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected entry value=%0d pos=%0d last=%0b rej=%0b",
					$time, got.value, got.position, got.last, got.rejected);
				mismatches++;
			end else begin
				want = pending_entries.pop_front();
				if (got !== want) begin
					$display({"%0t: expected value=%0d pos=%0d last=%0b rej=%0b, ",
						"got value=%0d pos=%0d last=%0b rej=%0b"},
						$time, want.value, want.position, want.last, want.rejected,
						got.value, got.position, got.last, got.rejected);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] new_char = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] entry_value;
	logic [sci_pkg::POS_W-1:0] entry_position;
	logic       last_entry;
	logic       rejected_full;

	bit quiet = 1'b0;
	sorted_store_board board = new();

	sorted_char_insert DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.new_char       (new_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entry_value    (entry_value),
		.entry_position (entry_position),
		.last_entry     (last_entry),
		.rejected_full  (rejected_full)
	);

	always #4 clk = ~clk;

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		new_char <= c;
		do begin
			@(negedge clk);
		end while (!in_ready);
		@(posedge clk);
		board.note_request(c);
	endtask

	task automatic drive_out_ready();
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 10) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_entry({entry_value, entry_position, last_entry, rejected_full});
		end
	end

	initial begin
		logic [7:0] directed [] = '{8'd128, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd1, 8'd254,
			8'd127, 8'd129, 8'd128, 8'd64, 8'd192, 8'd170, 8'd85, 8'd3, 8'd3, 8'd200,
			8'd10, 8'd100, 8'd15, 8'd240, 8'd2, 8'd253};
		int n_random;
		logic [7:0] c;
		n_random = 436;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		fork
			drive_out_ready();
		join_none
		@(posedge clk);
		foreach (directed[i]) begin
			send_char(directed[i]);
		end
		for (int i = 0; i < n_random; i++) begin
			if (i >= n_random - 60) begin
				quiet = 1'b1;
			end
			case ($urandom_range(0, 7))
				0: c = 8'd0;
				1: c = 8'd255;
				default: c = 8'($urandom_range(0, 255));
			endcase
			send_char(c);
		end
		in_valid <= 1'b0;
		while (board.pending_entries.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (board.mismatches == 0 && board.pending_entries.size() == 0) begin
			$display("sorted_char_insert: match");
		end else begin
			$display("sorted_char_insert: mismatch");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("%0t: timeout", $time);
		$display("sorted_char_insert: mismatch");
		$finish;
	end

endmodule
